[design/hsl2rgb_pkg.sv]
// Constants, widths and types shared by the HSL to RGB pixel converter.
package hsl2rgb_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS     = 12;
    localparam int HUE_FRAC_BITS = 4;

    // Field and datapath widths
    localparam int HUE_W   = 13;                  // hue field
    localparam int Q_W     = FRAC_BITS + 1;       // S, L, 1-|2L-1| (0..ONE)
    localparam int FRAC_W  = 10;                  // hue fraction within a sector
    localparam int C_W     = 2 * FRAC_BITS + 1;   // chroma, m, X in Q(2F)
    localparam int P_W     = C_W + FRAC_W;        // chroma * fraction
    localparam int DIV_SH  = 6;                   // SECTOR_SPAN = 15 << DIV_SH
    localparam int QD_W    = 28;                  // (chroma * fraction) >> DIV_SH
    localparam int SUM_W   = C_W + 1;             // channel sum before scaling
    localparam int BYTE_W  = 8;
    localparam int SCL_W   = SUM_W + BYTE_W;      // sum * 255
    localparam int NSTAGES = 8;

    // Spans and unit values
    localparam logic [Q_W-1:0]    ONE_Q       = Q_W'(1 << FRAC_BITS);
    localparam logic [FRAC_W-1:0] SECTOR_SPAN = FRAC_W'(60 << HUE_FRAC_BITS);
    localparam logic [HUE_W-1:0]  CIRCLE_SPAN = HUE_W'(360 << HUE_FRAC_BITS);
    localparam int                NUM_SECT    = 6;

    // Reciprocal of 15 for the divide by SECTOR_SPAN
    localparam int                RECIP_SH = 32;
    localparam int                RECIP_W  = 29;
    localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(286331153);
    localparam int                PROD_W   = QD_W + RECIP_W;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

    // Hue sectors, named by the (red, green, blue) ordering they produce
    typedef enum logic [2:0] {
        SEC_CX0 = 3'd0,
        SEC_XC0 = 3'd1,
        SEC_0CX = 3'd2,
        SEC_0XC = 3'd3,
        SEC_X0C = 3'd4,
        SEC_C0X = 3'd5
    } t_sector;

    // Scale a Q(2F) channel sum by 255, truncate and clamp to a byte
    function automatic logic [BYTE_W-1:0] to_byte(input logic [SUM_W-1:0] v);
        logic [SCL_W-1:0] scaled;
        logic [SCL_W-2*FRAC_BITS-1:0] top;
        scaled = (SCL_W'(v) << BYTE_W) - SCL_W'(v);
        top    = scaled[SCL_W-1:2*FRAC_BITS];
        if (top > (SCL_W-2*FRAC_BITS)'(BYTE_MAX)) begin
            return BYTE_MAX;
        end
        return top[BYTE_W-1:0];
    endfunction

endpackage

[design/hsl_to_rgb_pixel_converter.sv]
// HSL to RGB pixel converter: eight-stage pipeline, one pixel per clock.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | sink      | i_valid / o_ready  | i_hue[12:0], i_saturation[12:0],
//          |           |                    | i_lightness[12:0]
//  out     | source    | o_valid / i_ready  | o_red[7:0], o_green[7:0], o_blue[7:0]
//
//  One transfer in and one out per clock when the output is taken every cycle.
//  The stages, one register each, in order: wrap/clamp, sector, chroma multiply,
//  fraction multiply, reciprocal multiply, quotient fix-up, channel sums, byte scaling.
//  Synchronous active-low reset clears the valid bits; data registers are not reset.
//  A result held on the output freezes the whole pipeline and drops o_ready;
//  otherwise every stage advances each clock.
module hsl_to_rgb_pixel_converter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [hsl2rgb_pkg::HUE_W-1:0]    i_hue,
    input  logic [hsl2rgb_pkg::Q_W-1:0]      i_saturation,
    input  logic [hsl2rgb_pkg::Q_W-1:0]      i_lightness,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [hsl2rgb_pkg::BYTE_W-1:0]   o_red,
    output logic [hsl2rgb_pkg::BYTE_W-1:0]   o_green,
    output logic [hsl2rgb_pkg::BYTE_W-1:0]   o_blue
);
    import hsl2rgb_pkg::*;

    logic                 advance;
    logic [NSTAGES-1:0]   r_vld;

    // Stage 1: wrap hue, saturate S and L
    logic [HUE_W-1:0]     n_s1_h,  r_s1_h;
    logic [Q_W-1:0]       n_s1_s,  r_s1_s;
    logic [Q_W-1:0]       n_s1_l,  r_s1_l;

    // Stage 2: sector, fraction, 1-|2L-1|
    t_sector              n_s2_sec, r_s2_sec;
    logic [FRAC_W-1:0]    n_s2_frac, r_s2_frac;
    logic [Q_W-1:0]       n_s2_span, r_s2_span;
    logic [Q_W-1:0]       r_s2_s, r_s2_l;
    logic [HUE_W-1:0]     s2_base;
    logic [HUE_W-1:0]     s2_rem;
    logic [Q_W:0]         s2_twol;
    logic [Q_W-1:0]       s2_lgap;

    // Stage 3: chroma
    logic [C_W-1:0]       n_s3_c, r_s3_c;
    t_sector              r_s3_sec;
    logic [FRAC_W-1:0]    r_s3_frac;
    logic [Q_W-1:0]       r_s3_l;

    // Stage 4: chroma * fraction, pre-shifted by the power-of-two part of the span
    logic [P_W-1:0]       s4_prod;
    logic [QD_W-1:0]      n_s4_qd, r_s4_qd;
    logic [C_W-1:0]       r_s4_c;
    t_sector              r_s4_sec;
    logic [Q_W-1:0]       r_s4_l;

    // Stage 5: quotient estimate by reciprocal of 15, and m
    logic [PROD_W-1:0]    s5_prod;
    logic [C_W-1:0]       n_s5_est, r_s5_est;
    logic [C_W-1:0]       n_s5_m, r_s5_m;
    logic [QD_W-1:0]      r_s5_qd;
    logic [C_W-1:0]       r_s5_c;
    t_sector              r_s5_sec;

    // Stage 6: corrected secondary component X
    logic [QD_W-1:0]      s6_rem;
    logic [C_W-1:0]       n_s6_x, r_s6_x;
    logic [C_W-1:0]       r_s6_c, r_s6_m;
    t_sector              r_s6_sec;

    // Stage 7: channel sums
    logic [SUM_W-1:0]     n_s7_r, n_s7_g, n_s7_b;
    logic [SUM_W-1:0]     r_s7_r, r_s7_g, r_s7_b;
    logic [C_W-1:0]       s7_pr, s7_pg, s7_pb;

    // Stage 8: output bytes
    logic [BYTE_W-1:0]    r_red, r_green, r_blue;

    // Whole pipe moves unless the output holds a result that is not taken
    assign advance = ~r_vld[NSTAGES-1] | i_ready;
    assign o_ready = advance;
    assign o_valid = r_vld[NSTAGES-1];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[NSTAGES-2:0], i_valid};
        end
    end

    // Stage 1 logic: hue is below two full circles, one subtract wraps it
    always_comb begin
        n_s1_h = (i_hue >= CIRCLE_SPAN) ? i_hue - CIRCLE_SPAN : i_hue;
        n_s1_s = (i_saturation > ONE_Q) ? ONE_Q : i_saturation;
        n_s1_l = (i_lightness > ONE_Q) ? ONE_Q : i_lightness;
    end

    // Stage 2 logic
    always_comb begin
        n_s2_sec = SEC_CX0;
        s2_base  = '0;
        for (int k = 1; k < NUM_SECT; k++) begin
            if (r_s1_h >= HUE_W'(k * SECTOR_SPAN)) begin
                n_s2_sec = t_sector'(k);
                s2_base  = HUE_W'(k * SECTOR_SPAN);
            end
        end
        s2_rem = r_s1_h - s2_base;
        // Odd sectors run the fraction backwards
        if (n_s2_sec[0]) begin
            n_s2_frac = SECTOR_SPAN - s2_rem[FRAC_W-1:0];
        end else begin
            n_s2_frac = s2_rem[FRAC_W-1:0];
        end
        s2_twol = {r_s1_l, 1'b0};
        if (s2_twol >= (Q_W+1)'(ONE_Q)) begin
            s2_lgap = Q_W'(s2_twol - (Q_W+1)'(ONE_Q));
        end else begin
            s2_lgap = Q_W'((Q_W+1)'(ONE_Q) - s2_twol);
        end
        n_s2_span = ONE_Q - s2_lgap;
    end

    // Stage 3, 4, 5 logic
    always_comb begin
        n_s3_c   = C_W'(r_s2_span) * C_W'(r_s2_s);
        s4_prod  = P_W'(r_s3_c) * P_W'(r_s3_frac);
        n_s4_qd  = QD_W'(s4_prod >> DIV_SH);
        s5_prod  = PROD_W'(r_s4_qd) * PROD_W'(RECIP_15);
        n_s5_est = s5_prod[RECIP_SH +: C_W];
        n_s5_m   = (C_W'(r_s4_l) << FRAC_BITS) - (r_s4_c >> 1);
    end

    // Stage 6 logic: estimate is at most one low
    always_comb begin
        s6_rem = r_s5_qd - QD_W'((QD_W'(r_s5_est) << 4) - QD_W'(r_s5_est));
        n_s6_x = (s6_rem >= QD_W'(15)) ? r_s5_est + C_W'(1) : r_s5_est;
    end

    // Stage 7 logic: place C and X per sector
    always_comb begin
        s7_pr = '0;
        s7_pg = '0;
        s7_pb = '0;
        unique case (r_s6_sec)
            SEC_CX0: begin
                s7_pr = r_s6_c;
                s7_pg = r_s6_x;
            end
            SEC_XC0: begin
                s7_pr = r_s6_x;
                s7_pg = r_s6_c;
            end
            SEC_0CX: begin
                s7_pg = r_s6_c;
                s7_pb = r_s6_x;
            end
            SEC_0XC: begin
                s7_pg = r_s6_x;
                s7_pb = r_s6_c;
            end
            SEC_X0C: begin
                s7_pr = r_s6_x;
                s7_pb = r_s6_c;
            end
            default: begin
                s7_pr = r_s6_c;
                s7_pb = r_s6_x;
            end
        endcase
        n_s7_r = SUM_W'(s7_pr) + SUM_W'(r_s6_m);
        n_s7_g = SUM_W'(s7_pg) + SUM_W'(r_s6_m);
        n_s7_b = SUM_W'(s7_pb) + SUM_W'(r_s6_m);
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_h    <= n_s1_h;
            r_s1_s    <= n_s1_s;
            r_s1_l    <= n_s1_l;

            r_s2_sec  <= n_s2_sec;
            r_s2_frac <= n_s2_frac;
            r_s2_span <= n_s2_span;
            r_s2_s    <= r_s1_s;
            r_s2_l    <= r_s1_l;

            r_s3_c    <= n_s3_c;
            r_s3_sec  <= r_s2_sec;
            r_s3_frac <= r_s2_frac;
            r_s3_l    <= r_s2_l;

            r_s4_qd   <= n_s4_qd;
            r_s4_c    <= r_s3_c;
            r_s4_sec  <= r_s3_sec;
            r_s4_l    <= r_s3_l;

            r_s5_est  <= n_s5_est;
            r_s5_m    <= n_s5_m;
            r_s5_qd   <= r_s4_qd;
            r_s5_c    <= r_s4_c;
            r_s5_sec  <= r_s4_sec;

            r_s6_x    <= n_s6_x;
            r_s6_c    <= r_s5_c;
            r_s6_m    <= r_s5_m;
            r_s6_sec  <= r_s5_sec;

            r_s7_r    <= n_s7_r;
            r_s7_g    <= n_s7_g;
            r_s7_b    <= n_s7_b;

            r_red     <= to_byte(r_s7_r);
            r_green   <= to_byte(r_s7_g);
            r_blue    <= to_byte(r_s7_b);
        end
    end

endmodule
